// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the touch burst filter rtl
// no dependencies; the assertion forms drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBMF_ASSERT(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("tbmf assertion failed");
`define TBMF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tbmf implication failed");
`define TBMF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tbmf next-cycle check failed");
`else
`define TBMF_ASSERT(name, clk, rst_n, cond)
`define TBMF_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TBMF_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tbmf_pkg.sv =====
// types, constants and helpers of the touch burst filter
// used by every module in rtl/core; no dependencies
`timescale 1ns / 1ps

package tbmf_pkg;

	localparam int SAMPLE_W        = 12;
	localparam int POS_W           = 12;
	localparam int THR_W           = 12;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 12;
	localparam int DEF_SAMPLE_BITS = 12;
	localparam int BURST_LEN       = 9;
	localparam int GROUP_LEN       = 3;
	localparam int GROUPS          = 3;
	localparam int COUNT_W         = 4;
	localparam int GRP_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RUN_THR    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_THR  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED = CFG_IDX_W'(2);

	localparam logic [THR_W-1:0] RUN_THR_RESET   = THR_W'(2);
	localparam logic [THR_W-1:0] CALIB_THR_RESET = THR_W'(2);

	typedef enum logic [1:0] {
		OUTCOME_OK     = 2'd0,
		OUTCOME_LIFTED = 2'd1,
		OUTCOME_X_BAD  = 2'd2,
		OUTCOME_Y_BAD  = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x_sample;
		logic [SAMPLE_W-1:0] y_sample;
		logic                pen_lifted;
	} sample_word_t;

	typedef struct packed {
		outcome_t         outcome;
		logic [POS_W-1:0] x_position;
		logic [POS_W-1:0] y_position;
	} result_word_t;

	typedef struct packed {
		logic valid;
		logic aborted;
	} stage_ctl_t;

	// samples only carry SAMPLE_W bits on the port
	function automatic int eff_bits(input int sample_bits);
		return (sample_bits < SAMPLE_W) ? sample_bits : SAMPLE_W;
	endfunction

endpackage

// ===== rtl/core/tbmf_accum.sv =====
// burst accumulator: sample count, group sums and the s1 hand-off register
// depends on tbmf_pkg
`timescale 1ns / 1ps

module tbmf_accum #(
	parameter int SAMPLE_BITS = tbmf_pkg::DEF_SAMPLE_BITS,
	localparam int SW    = tbmf_pkg::eff_bits(SAMPLE_BITS),
	localparam int SUM_W = SW + 2
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  tbmf_pkg::sample_word_t                  in_word,
	input  logic                                    s2_ready,
	output tbmf_pkg::stage_ctl_t                    ctl_s1,
	output logic [tbmf_pkg::GROUPS-1:0][SUM_W-1:0]  x_sums_s1,
	output logic [tbmf_pkg::GROUPS-1:0][SUM_W-1:0]  y_sums_s1
);

	logic [tbmf_pkg::COUNT_W-1:0]           count_q;
	logic [tbmf_pkg::GROUPS-1:0][SUM_W-1:0] x_sum_q, y_sum_q;
	logic [tbmf_pkg::GROUPS-1:0][SUM_W-1:0] x_next, y_next;
	logic [tbmf_pkg::GRP_IDX_W-1:0]         grp;
	logic [SW-1:0]                          xs, ys;
	logic                                   last, accept, emit;

	always_comb begin
		xs = in_word.x_sample[SW-1:0];
		ys = in_word.y_sample[SW-1:0];
		if (count_q < tbmf_pkg::COUNT_W'(tbmf_pkg::GROUP_LEN)) begin
			grp = tbmf_pkg::GRP_IDX_W'(0);
		end else if (count_q < tbmf_pkg::COUNT_W'(2 * tbmf_pkg::GROUP_LEN)) begin
			grp = tbmf_pkg::GRP_IDX_W'(1);
		end else begin
			grp = tbmf_pkg::GRP_IDX_W'(2);
		end
		x_next      = x_sum_q;
		y_next      = y_sum_q;
		x_next[grp] = x_sum_q[grp] + SUM_W'(xs);
		y_next[grp] = y_sum_q[grp] + SUM_W'(ys);
		last        = (count_q == tbmf_pkg::COUNT_W'(tbmf_pkg::BURST_LEN - 1));
	end

	assign in_ready = !ctl_s1.valid || s2_ready;
	assign accept   = in_valid && in_ready;
	// ninth sample or an early lift closes the burst
	assign emit     = accept && (last || in_word.pen_lifted);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			x_sum_q <= '0;
			y_sum_q <= '0;
			ctl_s1  <= '0;
		end else begin
			if (emit) begin
				count_q <= '0;
				x_sum_q <= '0;
				y_sum_q <= '0;
			end else if (accept) begin
				count_q <= count_q + tbmf_pkg::COUNT_W'(1);
				x_sum_q <= x_next;
				y_sum_q <= y_next;
			end
			if (emit) begin
				ctl_s1.valid   <= 1'b1;
				ctl_s1.aborted <= !last;
			end else if (s2_ready) begin
				ctl_s1 <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			x_sums_s1 <= x_next;
			y_sums_s1 <= y_next;
		end
	end

endmodule

// ===== rtl/core/tbmf_avg.sv =====
// group averages: each group sum divided by three through a reciprocal multiply
// depends on tbmf_pkg
`timescale 1ns / 1ps

module tbmf_avg #(
	parameter int SAMPLE_BITS = tbmf_pkg::DEF_SAMPLE_BITS,
	localparam int SW    = tbmf_pkg::eff_bits(SAMPLE_BITS),
	localparam int SUM_W = SW + 2
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tbmf_pkg::stage_ctl_t                    ctl_s1,
	input  logic [tbmf_pkg::GROUPS-1:0][SUM_W-1:0]  x_sums_s1,
	input  logic [tbmf_pkg::GROUPS-1:0][SUM_W-1:0]  y_sums_s1,
	output logic                                    s2_ready,
	input  logic                                    out_free,
	output tbmf_pkg::stage_ctl_t                    ctl_s2,
	output logic [tbmf_pkg::GROUPS-1:0][SW-1:0]     x_avg_s2,
	output logic [tbmf_pkg::GROUPS-1:0][SW-1:0]     y_avg_s2
);

	// m = ceil(2^sh / 3) keeps the error below one sixth for any sum of SUM_W bits
	localparam int DIV_SH = SUM_W + 2;
	localparam int DIV_M  = ((1 << DIV_SH) + 2) / 3;
	localparam int PROD_W = SUM_W + DIV_SH + 1;

	logic [tbmf_pkg::GROUPS-1:0][PROD_W-1:0] x_prod, y_prod;
	logic [tbmf_pkg::GROUPS-1:0][SW-1:0]     x_avg, y_avg;

	always_comb begin
		for (int g = 0; g < tbmf_pkg::GROUPS; g++) begin
			x_prod[g] = PROD_W'(x_sums_s1[g]) * PROD_W'(DIV_M);
			y_prod[g] = PROD_W'(y_sums_s1[g]) * PROD_W'(DIV_M);
			x_avg[g]  = x_prod[g][DIV_SH +: SW];
			y_avg[g]  = y_prod[g][DIV_SH +: SW];
		end
	end

	assign s2_ready = !ctl_s2.valid || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (s2_ready) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && ctl_s1.valid) begin
			x_avg_s2 <= x_avg;
			y_avg_s2 <= y_avg;
		end
	end

endmodule

// ===== rtl/core/tbmf_axis_judge.sv =====
// one axis: pairwise spreads, stability check and pick of the closest pair
// depends on tbmf_pkg
`timescale 1ns / 1ps

module tbmf_axis_judge #(
	parameter int SAMPLE_BITS = tbmf_pkg::DEF_SAMPLE_BITS,
	localparam int SW = tbmf_pkg::eff_bits(SAMPLE_BITS)
) (
	input  logic [tbmf_pkg::GROUPS-1:0][SW-1:0] avg,
	input  logic [tbmf_pkg::THR_W-1:0]          thr,
	output logic                                ok,
	output logic [SW-1:0]                       pos
);

	logic [SW-1:0] a0, a1, a2;
	logic [SW-1:0] d01, d12, d20;
	logic [SW:0]   pair_sum;

	always_comb begin
		a0  = avg[0];
		a1  = avg[1];
		a2  = avg[2];
		d01 = (a0 > a1) ? a0 - a1 : a1 - a0;
		d12 = (a1 > a2) ? a1 - a2 : a2 - a1;
		d20 = (a2 > a0) ? a2 - a0 : a0 - a2;
		ok  = !((tbmf_pkg::THR_W'(d01) > thr) && (tbmf_pkg::THR_W'(d12) > thr)
			&& (tbmf_pkg::THR_W'(d20) > thr));
		// strict compares: on a tie, pair 1-2 wins over the others and pair 0-1 wins over pair 2-0
		if (d01 < d12) begin
			if (d20 < d01) begin
				pair_sum = (SW+1)'(a0) + (SW+1)'(a2);
			end else begin
				pair_sum = (SW+1)'(a0) + (SW+1)'(a1);
			end
		end else begin
			if (d20 < d12) begin
				pair_sum = (SW+1)'(a0) + (SW+1)'(a2);
			end else begin
				pair_sum = (SW+1)'(a1) + (SW+1)'(a2);
			end
		end
		pos = pair_sum[SW:1];
	end

endmodule

// ===== rtl/core/touch_burst_median_filter_core.sv =====
// top level of the touch burst filter: config registers, pipeline and result register
// depends on tbmf_pkg, tbmf_accum, tbmf_avg, tbmf_axis_judge, assert_macros.svh
`timescale 1ns / 1ps
//
//  port group   handshake                 payload
//  in           in_valid / in_ready       in_word  (tbmf_pkg::sample_word_t)
//  out          out_valid / out_ready     out_word (tbmf_pkg::result_word_t)
//  cfg          cfg_wr_en                 cfg_index, cfg_wdata
//
//  one word accepted per cycle while in_ready is high; the word that closes a burst moves
//  through the group sums, the averages and the judge into the result register
//  every stage holds its own valid bit, so a stalled output still lets earlier stages fill
//  in_ready drops only when the sum stage holds a result that cannot move on
//  reset clears the burst, the pipeline valids and the config registers to their defaults

`include "assert_macros.svh"

module touch_burst_median_filter_core #(
	parameter int SAMPLE_BITS = tbmf_pkg::DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tbmf_pkg::sample_word_t           in_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tbmf_pkg::result_word_t           out_word,
	input  logic                             cfg_wr_en,
	input  logic [tbmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbmf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int SW    = tbmf_pkg::eff_bits(SAMPLE_BITS);
	localparam int SUM_W = SW + 2;

	logic [tbmf_pkg::THR_W-1:0] run_thr_q, calib_thr_q, thr;
	logic                       calibrated_q;

	tbmf_pkg::stage_ctl_t                   ctl_s1, ctl_s2;
	logic [tbmf_pkg::GROUPS-1:0][SUM_W-1:0] x_sums_s1, y_sums_s1;
	logic [tbmf_pkg::GROUPS-1:0][SW-1:0]    x_avg_s2, y_avg_s2;
	logic                                   s2_ready, out_free;
	logic                                   x_ok, y_ok;
	logic [SW-1:0]                          x_pos, y_pos;
	logic                                   out_valid_q;
	tbmf_pkg::result_word_t                 out_word_q, result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_thr_q    <= tbmf_pkg::RUN_THR_RESET;
			calib_thr_q  <= tbmf_pkg::CALIB_THR_RESET;
			calibrated_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tbmf_pkg::CFG_RUN_THR:    run_thr_q    <= cfg_wdata[tbmf_pkg::THR_W-1:0];
				tbmf_pkg::CFG_CALIB_THR:  calib_thr_q  <= cfg_wdata[tbmf_pkg::THR_W-1:0];
				tbmf_pkg::CFG_CALIBRATED: calibrated_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign thr = calibrated_q ? run_thr_q : calib_thr_q;

	tbmf_accum #(.SAMPLE_BITS(SAMPLE_BITS)) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.s2_ready  (s2_ready),
		.ctl_s1    (ctl_s1),
		.x_sums_s1 (x_sums_s1),
		.y_sums_s1 (y_sums_s1)
	);

	tbmf_avg #(.SAMPLE_BITS(SAMPLE_BITS)) u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.x_sums_s1 (x_sums_s1),
		.y_sums_s1 (y_sums_s1),
		.s2_ready  (s2_ready),
		.out_free  (out_free),
		.ctl_s2    (ctl_s2),
		.x_avg_s2  (x_avg_s2),
		.y_avg_s2  (y_avg_s2)
	);

	tbmf_axis_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_x (
		.avg (x_avg_s2),
		.thr (thr),
		.ok  (x_ok),
		.pos (x_pos)
	);

	tbmf_axis_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_y (
		.avg (y_avg_s2),
		.thr (thr),
		.ok  (y_ok),
		.pos (y_pos)
	);

	// x is judged first; a rejected axis zeroes both positions
	always_comb begin
		result = '0;
		priority if (ctl_s2.aborted) begin
			result.outcome = tbmf_pkg::OUTCOME_LIFTED;
		end else if (!x_ok) begin
			result.outcome = tbmf_pkg::OUTCOME_X_BAD;
		end else if (!y_ok) begin
			result.outcome = tbmf_pkg::OUTCOME_Y_BAD;
		end else begin
			result.outcome    = tbmf_pkg::OUTCOME_OK;
			result.x_position = tbmf_pkg::POS_W'(x_pos);
			result.y_position = tbmf_pkg::POS_W'(y_pos);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && ctl_s2.valid) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`TBMF_ASSERT_NEXT(a_lift_closes_burst, clk, arst_n, in_valid && in_ready && in_word.pen_lifted, ctl_s1.valid)
	`TBMF_ASSERT_IMPL(a_reject_zero_pos, clk, arst_n, out_valid && (out_word.outcome != tbmf_pkg::OUTCOME_OK), (out_word.x_position == '0) && (out_word.y_position == '0))
	`TBMF_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, !in_ready, ctl_s1.valid && ctl_s2.valid && out_valid_q && !out_ready)
	`TBMF_ASSERT_IMPL(a_abort_is_valid, clk, arst_n, ctl_s2.aborted, ctl_s2.valid)

endmodule
